[hw/rtl/totp_pkg.sv]
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types, constants and helpers for the TOTP code generator.
// ----------------------------------------------------------------------------
package totp_pkg;

  // configuration register indexes
  localparam logic [2:0] RegKeyLow  = 3'd0;
  localparam logic [2:0] RegKeyMid  = 3'd1;
  localparam logic [2:0] RegKeyHigh = 3'd2;
  localparam logic [2:0] RegKeyLen  = 3'd3;
  localparam logic [2:0] RegDigits  = 3'd4;
  localparam logic [2:0] RegStep    = 3'd5;

  localparam logic [7:0] IpadByte = 8'h36;
  localparam logic [7:0] OpadByte = 8'h5C;

  // controller states
  typedef enum logic [3:0] {
    StIdle,
    StDiv,
    StLoad,
    StRound,
    StAdd,
    StTrunc,
    StMod,
    StOut
  } state_e;

  // block select for the message word source
  typedef enum logic [1:0] {
    BlkInnerKey,
    BlkInnerMsg,
    BlkOuterKey,
    BlkOuterMsg
  } blk_e;

  // controller to datapath commands
  typedef struct packed {
    logic   start;      // latch request, begin division
    logic   div_step;   // one restoring division step
    logic   init_chain; // load SHA-1 initial chain value
    logic   load_work;  // copy chain into working vars
    logic   round;      // one SHA-1 round
    logic   add_chain;  // fold working vars into chain
    logic   save_inner; // keep inner digest
    logic   trunc;      // dynamic truncation
    logic   mod_step;   // one step of the decimal reduction
    blk_e   blk;
    logic [6:0] rnd;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic mod_done;
  } stat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    rotl = d[63:32];
  endfunction

  function automatic logic [29:0] dec_pow(input logic [3:0] n);
    case (n)
      4'd0: dec_pow = 30'd1;
      4'd1: dec_pow = 30'd10;
      4'd2: dec_pow = 30'd100;
      4'd3: dec_pow = 30'd1000;
      4'd4: dec_pow = 30'd10000;
      4'd5: dec_pow = 30'd100000;
      4'd6: dec_pow = 30'd1000000;
      4'd7: dec_pow = 30'd10000000;
      4'd8: dec_pow = 30'd100000000;
      default: dec_pow = 30'd1000000000;
    endcase
  endfunction

endpackage

[hw/rtl/totp_code_generator.sv]
// ----------------------------------------------------------------------------
// totp_code_generator
// HMAC-SHA1 time-based one-time password engine.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one item: tdata[63:0] = unix_time.
//   m_axis returns one item per request:
//     tdata[29:0] = otp_code, tdata[45:30] = seconds_left, rest zero.
//   cfg_* writes registers 0..5 (key low/mid/high, key length, digits, step);
//   write only while no request is in flight.
// Sequence: division (64 quotient bits and a done check), four
//   compressions (load, 80 rounds, chain add each), one truncation step
//   and the reduction (31 bits and a done check). One request at a time,
//   set by the single shared SHA-1 round unit and the bit-serial dividers;
//   a new item is taken only after the last result has been accepted.
// Reset: registers return to zero key, 6 digits, 30 s step; idle, ready.
// Stall: the result holds on m_axis until tready; no new item is taken
//   meanwhile.
// ----------------------------------------------------------------------------
module totp_code_generator import totp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] unix_time
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [29:0] otp_code, [45:30] seconds_left
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [63:0] key_low_q, key_mid_q;
  logic [31:0] key_high_q;
  logic [4:0]  key_len_q;
  logic [3:0]  digits_q;
  logic [15:0] step_q;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_mid_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= '0;
      digits_q   <= 4'd6;
      step_q     <= 16'd30;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegKeyLow:  key_low_q  <= cfg_data_i;
        RegKeyMid:  key_mid_q  <= cfg_data_i;
        RegKeyHigh: key_high_q <= cfg_data_i[31:0];
        RegKeyLen:  key_len_q  <= cfg_data_i[4:0];
        RegDigits:  digits_q   <= cfg_data_i[3:0];
        RegStep:    step_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // key masked to its length, digit count and step saturated
  logic [159:0] key_raw, key_mask, key_eff;
  logic [4:0]   klen;
  logic [3:0]   nd;
  logic [15:0]  step_eff;

  assign key_raw  = {key_low_q, key_mid_q, key_high_q};
  assign klen     = (key_len_q > 5'd20) ? 5'd20 : key_len_q;
  always_comb begin
    for (int i = 0; i < 20; i++)
      key_mask[159 - 8*i -: 8] = (5'(i) < klen) ? 8'hFF : 8'h00;
  end
  assign key_eff  = key_raw & key_mask;
  assign nd       = (digits_q > 4'd9) ? 4'd9 : digits_q;
  assign step_eff = (step_q == 16'd0) ? 16'd1 : step_q;

  cmd_t  cmd;
  stat_t stat;
  logic [29:0] otp_code;
  logic [15:0] seconds_left;

  totp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  totp_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .unix_time_i    (s_axis_tdata),
    .key_i          (key_eff),
    .digits_i       (nd),
    .step_i         (step_eff),
    .otp_code_o     (otp_code),
    .seconds_left_o (seconds_left)
  );

  assign m_axis_tdata = {2'b00, seconds_left, otp_code};

endmodule

[hw/rtl/totp_ctrl.sv]
// ----------------------------------------------------------------------------
// totp_ctrl
// Sequencer: division, four SHA-1 compressions, truncation, reduction.
// ----------------------------------------------------------------------------
module totp_ctrl import totp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e     state_q, state_d;
  blk_e       blk_q, blk_d;
  logic [6:0] rnd_q, rnd_d;

  // next state
  always_comb begin
    state_d = state_q;
    blk_d   = blk_q;
    rnd_d   = rnd_q;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        state_d = StDiv;
        blk_d   = BlkInnerKey;
      end
      StDiv: if (stat_i.div_done) state_d = StLoad;
      StLoad: begin
        state_d = StRound;
        rnd_d   = 7'd0;
      end
      StRound: begin
        rnd_d = rnd_q + 7'd1;
        if (rnd_q == 7'd79) state_d = StAdd;
      end
      StAdd: begin
        if (blk_q == BlkOuterMsg) state_d = StTrunc;
        else begin
          state_d = StLoad;
          blk_d   = blk_e'(blk_q + 2'd1);
        end
      end
      StTrunc: state_d = StMod;
      StMod: if (stat_i.mod_done) state_d = StOut;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o       = '0;
    cmd_o.blk   = blk_q;
    cmd_o.rnd   = rnd_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o       = 1'b1;
        cmd_o.start      = in_valid_i;
        cmd_o.init_chain = in_valid_i;
      end
      StDiv:   cmd_o.div_step = 1'b1;
      StLoad: begin
        cmd_o.load_work  = 1'b1;
        cmd_o.init_chain = (blk_q == BlkOuterKey);
      end
      StRound: cmd_o.round = 1'b1;
      StAdd: begin
        cmd_o.add_chain  = 1'b1;
        cmd_o.save_inner = (blk_q == BlkInnerMsg);
      end
      StTrunc: cmd_o.trunc    = 1'b1;
      StMod:   cmd_o.mod_step = 1'b1;
      StOut:   out_valid_o    = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      blk_q   <= BlkInnerKey;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      blk_q   <= blk_d;
      rnd_q   <= rnd_d;
    end
  end

endmodule

[hw/rtl/totp_dpath.sv]
// ----------------------------------------------------------------------------
// totp_dpath
// Datapath: serial divider, one SHA-1 round unit, truncation, serial modulo.
// ----------------------------------------------------------------------------
module totp_dpath import totp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_t         cmd_i,
  output stat_t        stat_o,
  input  logic [63:0]  unix_time_i,
  input  logic [159:0] key_i,       // masked key, byte 0 in top bits
  input  logic [3:0]   digits_i,    // saturated to 9
  input  logic [15:0]  step_i,      // nonzero
  output logic [29:0]  otp_code_o,
  output logic [15:0]  seconds_left_o
);

  // restoring division of unix_time by step, one quotient bit a cycle
  logic [63:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [6:0]  dcnt_q, dcnt_d;
  logic [16:0] rem_sh;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dcnt_d = dcnt_q;
    rem_sh = {rem_q[15:0], quo_q[63]};
    if (cmd_i.start) begin
      quo_d  = unix_time_i;
      rem_d  = '0;
      dcnt_d = '0;
    end else if (cmd_i.div_step && dcnt_q != 7'd64) begin
      dcnt_d = dcnt_q + 7'd1;
      if (rem_sh >= {1'b0, step_i}) begin
        rem_d = rem_sh - {1'b0, step_i};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[62:0], 1'b0};
      end
    end
  end
  assign stat_o.div_done = (dcnt_q == 7'd64);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dcnt_q <= '0;
    else         dcnt_q <= dcnt_d;
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  // message word for rounds 0..15
  logic [31:0]  inner_q [5];
  logic [159:0] inner_flat;
  logic [511:0] blk_words;
  logic [511:0] pad_key;
  logic [7:0]   pad_byte;

  assign inner_flat = {inner_q[0], inner_q[1], inner_q[2], inner_q[3], inner_q[4]};
  assign pad_byte   = (cmd_i.blk == BlkInnerKey) ? IpadByte : OpadByte;
  assign pad_key    = {key_i, 352'd0} ^ {64{pad_byte}};

  always_comb begin
    case (cmd_i.blk)
      BlkInnerKey, BlkOuterKey: blk_words = pad_key;
      BlkInnerMsg: blk_words = {quo_q, 8'h80, 424'd0, 16'h0240};
      default:     blk_words = {inner_flat, 8'h80, 328'd0, 16'h02A0};
    endcase
  end

  // schedule window, a 16-word shift line
  logic [31:0] win_q [16];
  logic [31:0] w_cur;
  logic [3:0]  widx;

  assign widx  = cmd_i.rnd[3:0];
  assign w_cur = (cmd_i.rnd < 7'd16) ? blk_words[511 - 32*widx -: 32]
               : rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 5'd1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
      win_q[15] <= w_cur;
    end
  end

  // SHA-1 round unit
  logic [31:0] wv_q [5];
  logic [31:0] cv_q [5];
  logic [31:0] f, k, tmp;

  always_comb begin
    if (cmd_i.rnd < 7'd20) begin
      f = (wv_q[1] & wv_q[2]) | (~wv_q[1] & wv_q[3]);
      k = 32'h5A827999;
    end else if (cmd_i.rnd < 7'd40) begin
      f = wv_q[1] ^ wv_q[2] ^ wv_q[3];
      k = 32'h6ED9EBA1;
    end else if (cmd_i.rnd < 7'd60) begin
      f = (wv_q[1] & wv_q[2]) | (wv_q[1] & wv_q[3]) | (wv_q[2] & wv_q[3]);
      k = 32'h8F1BBCDC;
    end else begin
      f = wv_q[1] ^ wv_q[2] ^ wv_q[3];
      k = 32'hCA62C1D6;
    end
    tmp = rotl(wv_q[0], 5'd5) + f + wv_q[4] + k + w_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) begin
        wv_q[i] <= '0;
        cv_q[i] <= '0;
      end
    end else begin
      if (cmd_i.load_work) begin
        for (int i = 0; i < 5; i++) wv_q[i] <= cmd_i.init_chain ? 32'd0 : cv_q[i];
        if (cmd_i.init_chain) begin
          wv_q[0] <= 32'h67452301; wv_q[1] <= 32'hEFCDAB89; wv_q[2] <= 32'h98BADCFE;
          wv_q[3] <= 32'h10325476; wv_q[4] <= 32'hC3D2E1F0;
        end
      end else if (cmd_i.round) begin
        wv_q[4] <= wv_q[3];
        wv_q[3] <= wv_q[2];
        wv_q[2] <= rotl(wv_q[1], 5'd30);
        wv_q[1] <= wv_q[0];
        wv_q[0] <= tmp;
      end
      if (cmd_i.init_chain) begin
        cv_q[0] <= 32'h67452301; cv_q[1] <= 32'hEFCDAB89; cv_q[2] <= 32'h98BADCFE;
        cv_q[3] <= 32'h10325476; cv_q[4] <= 32'hC3D2E1F0;
      end else if (cmd_i.add_chain) begin
        for (int i = 0; i < 5; i++) cv_q[i] <= cv_q[i] + wv_q[i];
      end
    end
  end

  // inner digest store; the chain takes the sum only in the cycle after,
  // so capture the sum directly
  always_ff @(posedge clk_i) begin
    if (cmd_i.save_inner)
      for (int i = 0; i < 5; i++) inner_q[i] <= cv_q[i] + wv_q[i];
  end

  // dynamic truncation
  logic [159:0] dig;
  logic [3:0]   off;
  logic [31:0]  sel;
  assign dig = {cv_q[0], cv_q[1], cv_q[2], cv_q[3], cv_q[4]};
  assign off = dig[3:0];
  assign sel = dig[159 - 8*off -: 32];

  // modulo by 10^digits: restoring, one bit a cycle over 31 bits
  logic [30:0] mq_q, mq_d;
  logic [30:0] mr_q, mr_d;
  logic [5:0]  mcnt_q, mcnt_d;
  logic [30:0] mr_sh;
  logic [30:0] modv;

  assign modv  = {1'b0, dec_pow(digits_i)};
  assign mr_sh = {mr_q[29:0], mq_q[30]};

  always_comb begin
    mq_d   = mq_q;
    mr_d   = mr_q;
    mcnt_d = mcnt_q;
    if (cmd_i.trunc) begin
      mq_d   = sel[30:0];
      mr_d   = '0;
      mcnt_d = '0;
    end else if (cmd_i.mod_step && mcnt_q != 6'd31) begin
      mcnt_d = mcnt_q + 6'd1;
      mq_d   = {mq_q[29:0], 1'b0};
      mr_d   = (mr_sh >= modv) ? mr_sh - modv : mr_sh;
    end
  end
  assign stat_o.mod_done = (mcnt_q == 6'd31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mcnt_q <= '0;
    else         mcnt_q <= mcnt_d;
  end
  always_ff @(posedge clk_i) begin
    mq_q <= mq_d;
    mr_q <= mr_d;
  end

  assign otp_code_o     = mr_q[29:0];
  assign seconds_left_o = step_i - rem_q[15:0];

endmodule

[dv/totp_code_generator_test.sv]
// ----------------------------------------------------------------------------
// totp_code_generator_test
// Self-checking bench: a SHA-1/HMAC predictor computes each expected code and
// countdown; random bursts on the input, random stalls on the output, and
// several key/digit/step settings written between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module totp_code_generator_test;
  import totp_pkg::*;

  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [15:0] seconds_left;
    logic [29:0] otp_code;
  } totp_result_t;

  // key/digit/step settings mirrored from register writes
  logic [63:0] key_low_q, key_mid_q;
  logic [31:0] key_high_q;
  logic [4:0]  key_len_q;
  logic [3:0]  digits_q;
  logic [15:0] step_q;

  function automatic logic [31:0] rol32(logic [31:0] x, int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  // one SHA-1 compression over a 64-byte block
  function automatic void sha1_compress(ref logic [31:0] h[5], input logic [7:0] blk[64]);
    logic [31:0] w[80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rol32(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rol32(b, 30); b = a; a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
  endfunction

  function automatic void sha1_start(ref logic [31:0] h[5]);
    h[0] = 32'h67452301; h[1] = 32'hEFCDAB89; h[2] = 32'h98BADCFE;
    h[3] = 32'h10325476; h[4] = 32'hC3D2E1F0;
  endfunction

  // TOTP value for one timestamp under the current settings
  function automatic totp_result_t totp_predict(logic [63:0] now);
    logic [7:0]  key[64], blk[64], dig[20];
    logic [31:0] h[5], inner[5], code;
    logic [63:0] stp, ctr;
    int          klen, nd, off;
    totp_result_t r;
    klen = (key_len_q > 5'd20) ? 20 : int'(key_len_q);
    nd   = (digits_q > 4'd9) ? 9 : int'(digits_q);
    for (int i = 0; i < 64; i++) key[i] = '0;
    for (int i = 0; i < 8; i++) begin
      key[i]   = key_low_q[56-8*i +: 8];
      key[8+i] = key_mid_q[56-8*i +: 8];
    end
    for (int i = 0; i < 4; i++) key[16+i] = key_high_q[24-8*i +: 8];
    for (int i = klen; i < 20; i++) key[i] = '0;
    stp = (step_q == 0) ? 64'd1 : {48'd0, step_q};
    ctr = now / stp;
    // inner hash
    sha1_start(h);
    for (int i = 0; i < 64; i++) blk[i] = key[i] ^ IpadByte;
    sha1_compress(h, blk);
    for (int i = 0; i < 64; i++) blk[i] = '0;
    for (int i = 0; i < 8; i++) blk[i] = ctr[56-8*i +: 8];
    blk[8] = 8'h80; blk[62] = 8'h02; blk[63] = 8'h40;
    sha1_compress(h, blk);
    inner = h;
    // outer hash
    sha1_start(h);
    for (int i = 0; i < 64; i++) blk[i] = key[i] ^ OpadByte;
    sha1_compress(h, blk);
    for (int i = 0; i < 64; i++) blk[i] = '0;
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) blk[4*i+j] = inner[i][24-8*j +: 8];
    blk[20] = 8'h80; blk[62] = 8'h02; blk[63] = 8'hA0;
    sha1_compress(h, blk);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) dig[4*i+j] = h[i][24-8*j +: 8];
    // dynamic truncation
    off  = int'(dig[19][3:0]);
    code = {1'b0, dig[off][6:0], dig[off+1], dig[off+2], dig[off+3]};
    code = code % {2'b00, dec_pow(nd[3:0])};
    r.otp_code     = code[29:0];
    r.seconds_left = 16'(stp - (now % stp));
    return r;
  endfunction

  int unsigned mismatch_cnt = 0;

  task automatic report_mismatch(string what);
    $display("MISMATCH %0t: %s", $realtime, what);
    mismatch_cnt++;
  endtask

  class totp_scoreboard;
    totp_result_t pending_codes[$];
    int unsigned  checked_cnt = 0;

    function void note_request(totp_result_t r);
      pending_codes = {pending_codes, r};
    endfunction

    task check_result(logic [47:0] data);
      totp_result_t exp_r;
      if (pending_codes.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", data));
        return;
      end
      exp_r = pending_codes.pop_front();
      checked_cnt++;
      if (data[29:0] !== exp_r.otp_code)
        report_mismatch($sformatf("otp_code %0d, expected %0d", data[29:0], exp_r.otp_code));
      if (data[45:30] !== exp_r.seconds_left)
        report_mismatch($sformatf("seconds_left %0d, expected %0d", data[45:30],
                                  exp_r.seconds_left));
      if (data[47:46] !== 2'b00)
        report_mismatch($sformatf("pad bits %b not zero", data[47:46]));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;

  totp_scoreboard code_board = new();
  int unsigned    idle_cycles = 0;
  int unsigned    stall_mode = 0;

  always #4 clk_i = ~clk_i;

  totp_code_generator i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // result side: check accepted items, stall on a shifting pattern
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) code_board.check_result(m_axis_tdata);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
    if ($urandom_range(0, 499) == 0) stall_mode <= $urandom_range(0, 2);
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("totp_code_generator test failed");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegKeyLow:  key_low_q  = val;
      RegKeyMid:  key_mid_q  = val;
      RegKeyHigh: key_high_q = val[31:0];
      RegKeyLen:  key_len_q  = val[4:0];
      RegDigits:  digits_q   = val[3:0];
      RegStep:    step_q     = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_time(logic [63:0] now);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= now;
    do @(posedge clk_i); while (!s_axis_tready);
    code_board.note_request(totp_predict(now));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (code_board.pending_codes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] rand_time();
    case ($urandom_range(0, 3))
      0: return rand64();
      1: return {32'd0, $urandom()};
      2: return 64'd1700000000 + 64'($urandom_range(0, 100000000));
      default: return {$urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF_0000 : 64'd0} |
                      64'($urandom_range(0, 65535));
    endcase
  endfunction

  // bursts of requests with random gaps
  task automatic run_phase(int unsigned count);
    int unsigned left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 6);
      if (burst > left) burst = left;
      repeat (burst) send_time(rand_time());
      left -= burst;
      if ($urandom_range(0, 2) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 500)) @(posedge clk_i);
      end
    end
    drain();
  endtask

  initial begin
    key_low_q = '0; key_mid_q = '0; key_high_q = '0;
    key_len_q = '0; digits_q = 4'd6; step_q = 16'd30;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty key, 6 digits, 30 s step
    send_time(64'd59);
    send_time(64'd0);
    drain();

    // RFC 6238 key "12345678901234567890", 8 digits
    write_reg(RegKeyLow, 64'h3132333435363738);
    write_reg(RegKeyMid, 64'h3930313233343536);
    write_reg(RegKeyHigh, 64'h37383930);
    write_reg(RegKeyLen, 64'd20);
    write_reg(RegDigits, 64'd8);
    send_time(64'd59);
    send_time(64'd1111111109);
    send_time(64'd2000000000);
    send_time(64'd20000000000);
    send_time('1);
    send_time(64'h8000_0000_0000_0000);
    drain();

    // over-long key length, junk past short key, zero/over digits, zero/max step
    write_reg(RegKeyLen, 64'd31);
    write_reg(RegDigits, 64'd0);
    write_reg(RegStep, 64'd0);
    send_time(64'd12345);
    send_time('1);
    drain();
    write_reg(RegKeyLen, 64'd5);
    write_reg(RegDigits, 64'd15);
    write_reg(RegStep, 64'hFFFF);
    send_time(64'd0);
    send_time(64'd65534);
    send_time('1);
    drain();
    write_reg(RegDigits, 64'd1);
    write_reg(RegStep, 64'd1);
    send_time(64'd77);
    drain();
    write_reg(RegDigits, 64'd9);
    send_time(64'd77);
    drain();

    // random phases under random settings
    for (int p = 0; p < 15; p++) begin
      write_reg(RegKeyLow, rand64());
      write_reg(RegKeyMid, rand64());
      write_reg(RegKeyHigh, rand64());
      write_reg(RegKeyLen, 64'($urandom_range(0, 31)));
      write_reg(RegDigits, 64'($urandom_range(0, 15)));
      write_reg(RegStep, ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 65535))
                                                     : 64'($urandom_range(1, 120)));
      run_phase(100);
    end

    $display("checked %0d codes over directed cases and 15 random settings",
             code_board.checked_cnt);
    if (mismatch_cnt == 0 && code_board.pending_codes.size() == 0) begin
      $display("totp_code_generator test passed");
    end else begin
      $display("totp_code_generator test failed");
    end
    $finish;
  end

endmodule
